@@ hw/rtl/dynamic_min_spanning_forest_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dynamic minimum spanning forest block
// Shared forms of the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_MIN_SPANNING_FOREST_ASSERT_SVH
`define DYNAMIC_MIN_SPANNING_FOREST_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define DMSF_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define DMSF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dmsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Dynamic minimum spanning forest package
// Operation codes and the result record of the forest engine.
// ----------------------------------------------------------------------------
package dmsf_pkg;

    // Operation codes carried in the lowest bits of a request.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CONN   = 2'd2;
    localparam logic [1:0] OP_PATH   = 2'd3;

    // Fixed widths of the result fields.
    localparam int OUT_WEIGHT_W = 32;
    localparam int OUT_NODE_W   = 11;

    // Result record, last field in the lowest bits.
    typedef struct packed {
        logic                           bad_weight;
        logic [OUT_NODE_W-1:0]          max_node;
        logic signed [OUT_WEIGHT_W-1:0] max_weight;
        logic                           linked;
        logic                           joined;
        logic                           accepted;
    } t_result;

endpackage

@@ hw/rtl/dynamic_min_spanning_forest.sv @@
// ----------------------------------------------------------------------------
// Dynamic minimum spanning forest
// Keeps a weight-ordered parent-pointer forest with subtree counts in one
// node memory and serves add, remove, connected and path maximum requests.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload (low bits first)
//  s_axis    in         opcode, node_a, node_b, edge_weight
//  m_axis    out        accepted, joined, linked, max_weight, max_node, bad_weight
//
// Reset starts a clearing pass over every node entry, in which no request is taken.
// A trivial request is settled when it is taken; any other runs rebalancing steps
// (some with a rotation), path steps, and for a cut or merge link updates and
// count updates; each step waits on the one memory read port.
// A finished result waits in the output register while the next request is
// taken; a stalled output holds the engine only when a second result is ready.
// ----------------------------------------------------------------------------
`include "dynamic_min_spanning_forest_assert.svh"

module dynamic_min_spanning_forest #(
    parameter int NODES       = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], node_a[11:2], node_b[21:12], edge_weight[53:22], zero pad
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accepted[0], joined[1], linked[2], max_weight[34:3], max_node[45:35],
    // bad_weight[46], zero pad
    output logic [47:0] m_axis_tdata
);

    localparam int NB  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW  = $clog2(NODES + 1);
    localparam int CW  = PW;
    localparam int WB  = WEIGHT_BITS;
    localparam int XW  = ((WB > 32) ? WB : 32) + 1;
    localparam int IW  = ((PW > 10) ? PW : 10) + 1;
    localparam int ONW = dmsf_pkg::OUT_NODE_W;
    localparam int OWW = dmsf_pkg::OUT_WEIGHT_W;

    localparam logic [PW-1:0]        NONE   = PW'(NODES);
    localparam logic signed [WB-1:0] WMAX   = WB'((XW'(1) << (WB - 1)) - XW'(1));
    localparam logic signed [WB-1:0] WMIN   = ~WMAX;
    localparam logic signed [XW-1:0] WMAX_X = (XW'(1) << (WB - 1)) - XW'(1);
    localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;

    // Sequencer state codes.
    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] RB_FETCH = 5'd2;
    localparam logic [4:0] RB_LOAD  = 5'd3;
    localparam logic [4:0] RB_CHK   = 5'd4;
    localparam logic [4:0] RB_EVAL  = 5'd5;
    localparam logic [4:0] RB_WV    = 5'd6;
    localparam logic [4:0] PF_A     = 5'd7;
    localparam logic [4:0] PF_B     = 5'd8;
    localparam logic [4:0] PF_C     = 5'd9;
    localparam logic [4:0] P_LOOP   = 5'd10;
    localparam logic [4:0] P_LOAD   = 5'd11;
    localparam logic [4:0] S_DECIDE = 5'd12;
    localparam logic [4:0] C_FETCH  = 5'd13;
    localparam logic [4:0] C_LOAD   = 5'd14;
    localparam logic [4:0] CH_CHK   = 5'd15;
    localparam logic [4:0] CH_UPD   = 5'd16;
    localparam logic [4:0] MG_F     = 5'd17;
    localparam logic [4:0] MG_G     = 5'd18;
    localparam logic [4:0] MG_H     = 5'd19;
    localparam logic [4:0] M_TEST   = 5'd20;
    localparam logic [4:0] M_ADD    = 5'd21;
    localparam logic [4:0] M_SP1    = 5'd22;
    localparam logic [4:0] M_SP2    = 5'd23;
    localparam logic [4:0] S_DONE   = 5'd24;

    typedef struct packed {
        logic [PW-1:0]        parent;
        logic [CW-1:0]        count;
        logic signed [WB-1:0] weight;
    } t_entry;

    // Sign-extends a stored weight and keeps the result field's bits.
    function automatic logic [OWW-1:0] to_out(input logic signed [WB-1:0] v);
        logic signed [XW-1:0] e;
        e = {{(XW - WB){v[WB-1]}}, v};
        return e[OWW-1:0];
    endfunction

    logic [4:0]           r_state, n_state;
    logic [NB-1:0]        r_clr, n_clr;
    logic [1:0]           r_op, n_op;
    logic [PW-1:0]        r_a, n_a, r_b, n_b;
    logic signed [WB-1:0] r_w, n_w;
    logic                 r_phase, n_phase;
    logic                 r_cont, n_cont;
    logic [PW-1:0]        r_x, n_x;
    logic [CW-1:0]        r_del, n_del;
    logic [PW-1:0]        r_u, n_u, r_v, n_v;
    t_entry               r_eu, n_eu, r_ev, n_ev;
    logic [CW-1:0]        r_du, n_du, r_dv, n_dv;
    logic signed [WB-1:0] r_mw, n_mw;
    logic                 r_side, n_side;
    logic signed [WB-1:0] r_best, n_best;
    logic [PW-1:0]        r_at, n_at;
    logic                 r_found, n_found;
    logic                 r_conn, n_conn;
    dmsf_pkg::t_result    r_res, n_res;
    dmsf_pkg::t_result    r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 w_ram_we;
    logic [NB-1:0]        w_ram_waddr;
    t_entry               w_ram_wdata;
    logic [NB-1:0]        w_ram_raddr;
    t_entry               w_rd;
    logic [$bits(t_entry)-1:0] w_rd_bits;

    // Node memory: parent, subtree count and weight of the link to the parent.
    dmsf_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rd_bits)
    );

    assign w_rd = t_entry'(w_rd_bits);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // Sequencer: at most one memory read and one memory write per step.
    always_comb begin
        logic [1:0]           in_op;
        logic [9:0]           in_a, in_b;
        logic [31:0]          in_w;
        logic signed [XW-1:0] wx;
        logic                 in_range;
        logic [CW+1:0]        three_cv, two_cp;
        logic [CW-1:0]        cpn;
        t_entry               np, nv, ne;
        logic                 sw;
        logic [PW-1:0]        sx, sy;
        t_entry               ex, ey;
        logic signed [WB-1:0] pm;
        logic [PW-1:0]        pn;

        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_w         = r_w;
        n_phase     = r_phase;
        n_cont      = r_cont;
        n_x         = r_x;
        n_del       = r_del;
        n_u         = r_u;
        n_v         = r_v;
        n_eu        = r_eu;
        n_ev        = r_ev;
        n_du        = r_du;
        n_dv        = r_dv;
        n_mw        = r_mw;
        n_side      = r_side;
        n_best      = r_best;
        n_at        = r_at;
        n_found     = r_found;
        n_conn      = r_conn;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_ram_we    = 1'b0;
        w_ram_waddr = '0;
        w_ram_wdata = '0;
        w_ram_raddr = '0;

        in_op    = s_axis_tdata[1:0];
        in_a     = s_axis_tdata[11:2];
        in_b     = s_axis_tdata[21:12];
        in_w     = s_axis_tdata[53:22];
        wx       = {{(XW - 32){in_w[31]}}, in_w};
        in_range = (IW'(in_a) < IW'(NODES)) && (IW'(in_b) < IW'(NODES));
        three_cv = ((CW + 2)'(r_eu.count) << 1) + (CW + 2)'(r_eu.count);
        two_cp   = (CW + 2)'(w_rd.count) << 1;
        cpn      = w_rd.count - r_eu.count;
        np       = w_rd;
        nv       = r_eu;
        ne       = w_rd;
        sw       = r_eu.count > r_ev.count;
        sx       = sw ? r_v : r_u;
        sy       = sw ? r_u : r_v;
        ex       = sw ? r_ev : r_eu;
        ey       = sw ? r_eu : r_ev;
        pm       = r_conn ? r_best : WMAX;
        pn       = r_conn ? r_at : NONE;

        // Output register empties when the result is taken.
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            // Clearing pass over every node entry.
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = '{parent: NONE, count: CW'(1), weight: WMAX};
                if (r_clr == NB'(NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + NB'(1);
                end
            end
            // Take a request and settle the trivial cases at once.
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op  = in_op;
                    n_a   = PW'(in_a);
                    n_b   = PW'(in_b);
                    n_w   = WB'(wx);
                    n_res = '0;
                    n_res.max_node = ONW'(NONE);
                    n_phase = 1'b0;
                    n_x     = PW'(in_a);
                    if ((in_op == dmsf_pkg::OP_ADD) || (in_op == dmsf_pkg::OP_REMOVE)) begin
                        if ((wx >= WMAX_X) || (wx < WMIN_X)) begin
                            n_res.bad_weight = 1'b1;
                            n_state = S_DONE;
                        end else if (!in_range || (in_a == in_b)) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = RB_FETCH;
                        end
                    end else begin
                        n_res.max_weight = to_out(WMAX);
                        if (!in_range) begin
                            n_state = S_DONE;
                        end else if ((in_op == dmsf_pkg::OP_CONN) && (in_a == in_b)) begin
                            n_res.linked     = 1'b1;
                            n_res.max_weight = to_out(WMIN);
                            n_state = S_DONE;
                        end else begin
                            n_state = RB_FETCH;
                        end
                    end
                end
            end
            // Rebalancing walk from each of the two vertices up to its root.
            RB_FETCH: begin
                w_ram_raddr = r_x[NB-1:0];
                n_state = RB_LOAD;
            end
            RB_LOAD: begin
                n_eu = w_rd;
                n_state = RB_CHK;
            end
            RB_CHK: begin
                if (r_eu.parent == NONE) begin
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_x     = r_b;
                        n_state = RB_FETCH;
                    end else begin
                        n_state = PF_A;
                    end
                end else begin
                    w_ram_raddr = r_eu.parent[NB-1:0];
                    n_state = RB_EVAL;
                end
            end
            RB_EVAL: begin
                if (three_cv <= two_cp) begin
                    n_x  = r_eu.parent;
                    n_eu = w_rd;
                    n_state = RB_CHK;
                end else begin
                    np.count  = cpn;
                    nv.parent = w_rd.parent;
                    if (r_eu.weight < w_rd.weight) begin
                        nv.count  = r_eu.count + cpn;
                        nv.weight = w_rd.weight;
                        np.weight = r_eu.weight;
                        np.parent = r_x;
                    end
                    w_ram_we    = 1'b1;
                    w_ram_waddr = r_eu.parent[NB-1:0];
                    w_ram_wdata = np;
                    n_eu = nv;
                    n_state = RB_WV;
                end
            end
            RB_WV: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_x[NB-1:0];
                w_ram_wdata = r_eu;
                n_state = RB_CHK;
            end
            // Path search between the two vertices.
            PF_A: begin
                w_ram_raddr = r_a[NB-1:0];
                n_state = PF_B;
            end
            PF_B: begin
                n_eu = w_rd;
                w_ram_raddr = r_b[NB-1:0];
                n_state = PF_C;
            end
            PF_C: begin
                n_ev    = w_rd;
                n_u     = r_a;
                n_v     = r_b;
                n_best  = WMIN;
                n_at    = NONE;
                n_found = 1'b0;
                n_state = P_LOOP;
            end
            P_LOOP: begin
                if (r_u == r_v) begin
                    n_conn  = 1'b1;
                    n_state = S_DECIDE;
                end else if ((ex.weight == WMAX) || (ex.parent == NONE)) begin
                    n_conn  = 1'b0;
                    n_state = S_DECIDE;
                end else begin
                    if (!r_found || (ex.weight > r_best)) begin
                        n_best = ex.weight;
                        n_at   = sx;
                    end
                    n_found = 1'b1;
                    n_u  = ex.parent;
                    n_v  = sy;
                    n_ev = ey;
                    w_ram_raddr = ex.parent[NB-1:0];
                    n_state = P_LOAD;
                end
            end
            P_LOAD: begin
                n_eu = w_rd;
                n_state = P_LOOP;
            end
            // Act on the path maximum.
            S_DECIDE: begin
                if ((r_op == dmsf_pkg::OP_CONN) || (r_op == dmsf_pkg::OP_PATH)) begin
                    n_res.linked     = r_conn;
                    n_res.max_weight = to_out(pm);
                    n_res.max_node   = ONW'(pn);
                    n_state = S_DONE;
                end else if (r_op == dmsf_pkg::OP_ADD) begin
                    if (!r_conn) begin
                        n_res.accepted = 1'b1;
                        n_res.joined   = 1'b1;
                        n_state = MG_F;
                    end else if ((r_w < pm) && (pn != NONE)) begin
                        n_res.accepted = 1'b1;
                        n_cont  = 1'b1;
                        n_state = C_FETCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    if (r_conn && (pn != NONE) && (pm == r_w)) begin
                        n_res.accepted = 1'b1;
                        n_cont  = 1'b0;
                        n_state = C_FETCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            // Cut the heaviest link and take its count off every ancestor.
            C_FETCH: begin
                w_ram_raddr = r_at[NB-1:0];
                n_state = C_LOAD;
            end
            C_LOAD: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_at[NB-1:0];
                w_ram_wdata = '{parent: NONE, count: w_rd.count, weight: WMAX};
                n_x   = w_rd.parent;
                n_del = CW'(0) - w_rd.count;
                n_state = CH_CHK;
            end
            // Add a count change along a parent chain.
            CH_CHK: begin
                if (r_x == NONE) begin
                    n_state = r_cont ? MG_F : S_DONE;
                end else begin
                    w_ram_raddr = r_x[NB-1:0];
                    n_state = CH_UPD;
                end
            end
            CH_UPD: begin
                ne.count    = w_rd.count + r_del;
                w_ram_we    = 1'b1;
                w_ram_waddr = r_x[NB-1:0];
                w_ram_wdata = ne;
                n_x = w_rd.parent;
                n_state = CH_CHK;
            end
            // Merge the two root paths in weight order.
            MG_F: begin
                w_ram_raddr = r_a[NB-1:0];
                n_state = MG_G;
            end
            MG_G: begin
                n_eu = w_rd;
                w_ram_raddr = r_b[NB-1:0];
                n_state = MG_H;
            end
            MG_H: begin
                n_ev = w_rd;
                n_u  = r_a;
                n_v  = r_b;
                n_du = '0;
                n_dv = '0;
                n_mw = r_w;
                n_state = M_TEST;
            end
            M_TEST: begin
                if ((r_u == NONE) || (r_v == NONE)) begin
                    n_x     = (r_v != NONE) ? r_ev.parent : NONE;
                    n_del   = r_dv;
                    n_cont  = 1'b0;
                    n_state = CH_CHK;
                end else if (r_mw >= r_eu.weight) begin
                    n_u = r_eu.parent;
                    if (r_eu.parent != NONE) begin
                        n_side = 1'b0;
                        w_ram_raddr = r_eu.parent[NB-1:0];
                        n_state = M_ADD;
                    end
                end else if (r_mw >= r_ev.weight) begin
                    n_v = r_ev.parent;
                    if (r_ev.parent != NONE) begin
                        n_side = 1'b1;
                        w_ram_raddr = r_ev.parent[NB-1:0];
                        n_state = M_ADD;
                    end
                end else begin
                    if (sw) begin
                        n_u  = r_v;
                        n_v  = r_u;
                        n_eu = r_ev;
                        n_ev = r_eu;
                        n_du = r_dv;
                        n_dv = r_du;
                    end
                    n_state = M_SP1;
                end
            end
            M_ADD: begin
                ne.count    = w_rd.count + (r_side ? r_dv : r_du);
                w_ram_we    = 1'b1;
                w_ram_waddr = r_side ? r_v[NB-1:0] : r_u[NB-1:0];
                w_ram_wdata = ne;
                if (r_side || (r_u == r_v)) begin
                    n_ev = ne;
                end
                if (!r_side || (r_u == r_v)) begin
                    n_eu = ne;
                end
                n_state = M_TEST;
            end
            M_SP1: begin
                n_du = r_du - r_eu.count;
                n_dv = r_dv + r_eu.count;
                nv   = r_ev;
                nv.count    = r_ev.count + r_eu.count;
                w_ram_we    = 1'b1;
                w_ram_waddr = r_v[NB-1:0];
                w_ram_wdata = nv;
                n_ev = nv;
                if (r_u == r_v) begin
                    n_eu = nv;
                end
                n_state = M_SP2;
            end
            M_SP2: begin
                ne = '{parent: r_v, count: r_eu.count, weight: r_mw};
                w_ram_we    = 1'b1;
                w_ram_waddr = r_u[NB-1:0];
                w_ram_wdata = ne;
                if (r_v == r_u) begin
                    n_ev = ne;
                end
                n_mw = r_eu.weight;
                n_u  = r_eu.parent;
                if (r_eu.parent != NONE) begin
                    n_side = 1'b0;
                    w_ram_raddr = r_eu.parent[NB-1:0];
                    n_state = M_ADD;
                end else begin
                    n_state = M_TEST;
                end
            end
            // Hand the result to the output register.
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_a     <= n_a;
        r_b     <= n_b;
        r_w     <= n_w;
        r_phase <= n_phase;
        r_cont  <= n_cont;
        r_x     <= n_x;
        r_del   <= n_del;
        r_u     <= n_u;
        r_v     <= n_v;
        r_eu    <= n_eu;
        r_ev    <= n_ev;
        r_du    <= n_du;
        r_dv    <= n_dv;
        r_mw    <= n_mw;
        r_side  <= n_side;
        r_best  <= n_best;
        r_at    <= n_at;
        r_found <= n_found;
        r_conn  <= n_conn;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Checks on the sequencer.
    `DMSF_ASSERT_IMPLIES(a_clear_blocks_input, i_clk, i_rst_n, r_state == S_CLEAR, !s_axis_tready, "request taken during clearing pass")
    `DMSF_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state != S_IDLE, "request taken but engine stayed idle")
    `DMSF_ASSERT_IMPLIES(a_no_write_idle, i_clk, i_rst_n, r_state == S_IDLE, !w_ram_we, "node memory written while idle")

endmodule

@@ hw/rtl/dmsf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data; a read of the
// entry being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module dmsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read with write-first bypass.
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
